@@ design/cc20_pkg.sv @@
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the quarter-round function of the ChaCha20
// keystream generator.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int unsigned DEF_ROUNDS = 20;
	localparam int unsigned WORDS      = 16;
	localparam int unsigned CFG_W      = 64;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned IDX_W      = 5;

	typedef logic [31:0] word_t;

	localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY01 = 3'd0,
		REG_KEY23 = 3'd1,
		REG_KEY45 = 3'd2,
		REG_KEY67 = 3'd3,
		REG_NONCE = 3'd4,
		REG_START = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FEED,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       ctr_reload;
		logic       init;
		logic       round;
		logic       diag;
		logic       feed;
		logic       emit;
		logic [3:0] rd_idx;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic quad_t qr(quad_t q);
		quad_t r;
		r = q;
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
		return r;
	endfunction

endpackage

@@ design/cc20_req_if.sv @@
// ----------------------------------------------------------------------------
// cc20_req_if
// Request channel: one transaction asks for one keystream word.
// ----------------------------------------------------------------------------
interface cc20_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

@@ design/cc20_word_if.sv @@
// ----------------------------------------------------------------------------
// cc20_word_if
// Keystream channel: one transaction carries one 32-bit word.
// ----------------------------------------------------------------------------
interface cc20_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

@@ design/cc20_ctrl.sv @@
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: request handshake, buffer index, round count and commands to
// the datapath.
// ----------------------------------------------------------------------------
module cc20_ctrl import cc20_pkg::*; #(
	parameter int unsigned ROUNDS = DEF_ROUNDS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_restart,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int unsigned NR   = (ROUNDS / 2) * 2;
	localparam int unsigned RW   = $clog2(NR);
	localparam logic [RW-1:0] RLAST = RW'(NR - 1);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [RW-1:0]     rnd_q;
	logic              acc;

	assign acc = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (acc) state_d = (req_restart || idx_q[IDX_W-1]) ? ST_LOAD : ST_EMIT;
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == RLAST) state_d = ST_FEED;
			ST_FEED:  state_d = ST_EMIT;
			ST_EMIT:  if (!sts.out_full) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready      = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.ctr_reload = acc && req_restart;
		cmd.init       = (state_q == ST_LOAD);
		cmd.round      = (state_q == ST_ROUND);
		cmd.diag       = rnd_q[0];
		cmd.feed       = (state_q == ST_FEED);
		cmd.emit       = (state_q == ST_EMIT) && !sts.out_full;
		cmd.rd_idx     = idx_q[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= IDX_W'(WORDS);
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.ctr_reload) idx_q <= IDX_W'(WORDS);
			else if (cmd.feed)  idx_q <= '0;
			else if (cmd.emit)  idx_q <= idx_q + 1'b1;
			if (cmd.init)       rnd_q <= '0;
			else if (cmd.round) rnd_q <= rnd_q + 1'b1;
		end
	end

endmodule

@@ design/cc20_core.sv @@
// ----------------------------------------------------------------------------
// cc20_core
// Datapath: configuration registers, block counter, 16-word state with one
// column or diagonal round per cycle, feed-forward and output register.
// ----------------------------------------------------------------------------
module cc20_core import cc20_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output word_t                out_word
);

	logic [63:0] key_q [4];
	logic [63:0] nonce_q;
	logic [63:0] start_q;
	logic [63:0] ctr_q;
	word_t       w_q    [WORDS];
	word_t       init_w [WORDS];
	word_t       col_w  [WORDS];
	word_t       dia_w  [WORDS];
	logic        out_valid_q;
	word_t       out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '{default: '0};
			nonce_q <= '0;
			start_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KEY01: key_q[0] <= cfg_data;
				REG_KEY23: key_q[1] <= cfg_data;
				REG_KEY45: key_q[2] <= cfg_data;
				REG_KEY67: key_q[3] <= cfg_data;
				REG_NONCE: nonce_q  <= cfg_data;
				REG_START: start_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = SIGMA[i];
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = ctr_q[31:0];
		init_w[13] = ctr_q[63:32];
		init_w[14] = nonce_q[31:0];
		init_w[15] = nonce_q[63:32];
	end

	for (genvar g = 0; g < 4; g++) begin : g_qr
		localparam int unsigned DB = 4 + ((g + 1) % 4);
		localparam int unsigned DC = 8 + ((g + 2) % 4);
		localparam int unsigned DD = 12 + ((g + 3) % 4);
		quad_t col_r, dia_r;
		assign col_r = qr({w_q[g], w_q[4 + g], w_q[8 + g], w_q[12 + g]});
		assign dia_r = qr({w_q[g], w_q[DB], w_q[DC], w_q[DD]});
		assign col_w[g]      = col_r.a;
		assign col_w[4 + g]  = col_r.b;
		assign col_w[8 + g]  = col_r.c;
		assign col_w[12 + g] = col_r.d;
		assign dia_w[g]      = dia_r.a;
		assign dia_w[DB]     = dia_r.b;
		assign dia_w[DC]     = dia_r.c;
		assign dia_w[DD]     = dia_r.d;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WORDS; i++) begin
			if (cmd.init)       w_q[i] <= init_w[i];
			else if (cmd.round) w_q[i] <= cmd.diag ? dia_w[i] : col_w[i];
			else if (cmd.feed)  w_q[i] <= w_q[i] + init_w[i];
		end
		if (cmd.emit) out_word_q <= w_q[cmd.rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ctr_reload) ctr_q <= start_q;
			else if (cmd.feed)  ctr_q <= ctr_q + 64'd1;
			if (cmd.emit)           out_valid_q <= 1'b1;
			else if (out_ready)     out_valid_q <= 1'b0;
		end
	end

	assign sts.out_full = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;

endmodule

@@ design/chacha20_keystream_generator_top.sv @@
// Per request: EMIT registers the next buffered word; when the buffer is
//   empty or a restart is asked, LOAD, ROUND and FEED compute a block first.
// One request at a time: a new one is taken only once the word is registered.
// Every 16th word, or a restart, needs a new block: one round per cycle.
// Reset: registers and block counter cleared, buffer empty, no words out.
// ----------------------------------------------------------------------------
// chacha20_keystream_generator_top
// ChaCha20 (64-bit counter and nonce) keystream word generator.
// ----------------------------------------------------------------------------
module chacha20_keystream_generator_top import cc20_pkg::*; #(
	parameter int unsigned ROUNDS = DEF_ROUNDS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	cc20_req_if.sink             request,
	cc20_word_if.source          keystream
);

	cmd_t cmd;
	sts_t sts;

	cc20_ctrl #(
		.ROUNDS (ROUNDS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (request.valid),
		.req_restart (request.restart),
		.req_ready   (request.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	cc20_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (keystream.valid),
		.out_ready (keystream.ready),
		.out_word  (keystream.random_word)
	);

endmodule

@@ design/cc20_chk.sv @@
// ----------------------------------------------------------------------------
// cc20_chk
// Port-level checks on request/word ordering, bound to the top level.
// ----------------------------------------------------------------------------
module cc20_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else         pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
	end

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("word changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("word without pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests in flight");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request taken while busy");

endmodule

bind chacha20_keystream_generator_top cc20_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (request.valid),
	.in_ready  (request.ready),
	.out_valid (keystream.valid),
	.out_ready (keystream.ready),
	.out_word  (keystream.random_word)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the ChaCha20 keystream generator against a block-level predictor.
// The predictor keeps its own key, nonce, counter and 16-word buffer. Each
// accepted request is turned into the expected keystream word, and every
// word that leaves the block is compared with the oldest one waiting.
// Directed tests cover reset defaults, all-ones key and nonce with counter
// wrap, and key and counter writes taking effect only at the next block or
// restart. They are followed by random phases of requests under random
// configuration, with random request gaps and keystream back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cc20_pkg::*;

	localparam int unsigned N_ROUNDS = DEF_ROUNDS;
	localparam int unsigned ITEMS    = 1850;
	localparam int unsigned LIMIT    = 400000;
	localparam int unsigned SETTLE   = N_ROUNDS + 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	cc20_req_if  req_ch ();
	cc20_word_if word_ch ();

	chacha20_keystream_generator_top #(
		.ROUNDS(N_ROUNDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.request  (req_ch),
		.keystream(word_ch)
	);

	// predictor state
	logic [63:0] key_reg [4];
	logic [63:0] nonce_reg;
	logic [63:0] start_reg;
	logic [63:0] blk_ctr;
	word_t       ks_buf [WORDS];
	int unsigned ks_pos;
	word_t       mix [WORDS];

	word_t       words_due [$];
	word_t       word_exp;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit          calm = 1'b0;

	function automatic word_t rol32(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void qround(int unsigned a, int unsigned b, int unsigned c,
			int unsigned d);
		mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
		mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
		mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
		mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
	endfunction

	function automatic void refill_block();
		word_t seed [WORDS];
		for (int i = 0; i < 4; i++) begin
			seed[i] = SIGMA[i];
			seed[4 + 2 * i] = key_reg[i][31:0];
			seed[5 + 2 * i] = key_reg[i][63:32];
		end
		seed[12] = blk_ctr[31:0];
		seed[13] = blk_ctr[63:32];
		seed[14] = nonce_reg[31:0];
		seed[15] = nonce_reg[63:32];
		mix = seed;
		for (int r = 0; r < N_ROUNDS / 2; r++) begin
			qround(0, 4, 8, 12);
			qround(1, 5, 9, 13);
			qround(2, 6, 10, 14);
			qround(3, 7, 11, 15);
			qround(0, 5, 10, 15);
			qround(1, 6, 11, 12);
			qround(2, 7, 8, 13);
			qround(3, 4, 9, 14);
		end
		for (int i = 0; i < WORDS; i++)
			ks_buf[i] = mix[i] + seed[i];
		blk_ctr = blk_ctr + 64'd1;
	endfunction

	function automatic word_t next_word(logic restart);
		word_t w;
		if (restart) begin
			blk_ctr = start_reg;
			ks_pos  = WORDS;
		end
		if (ks_pos >= WORDS) begin
			refill_block();
			ks_pos = 0;
		end
		w = ks_buf[ks_pos];
		ks_pos++;
		return w;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("chacha20_keystream_generator_top regression: fail");
			$finish;
		end
	end

	initial begin
		word_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			word_ch.ready = calm || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_ch.valid === 1'b1 && word_ch.ready === 1'b1) begin
			if (words_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none actual %h",
					$time, word_ch.random_word);
			end else begin
				word_exp = words_due.pop_front();
				if (word_ch.random_word !== word_exp) begin
					errors++;
					$display("%0t: random_word expected %h actual %h",
						$time, word_exp, word_ch.random_word);
				end
			end
		end
	end

	task automatic send_request(logic restart);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 15) begin
			req_ch.valid   = 1'b0;
			req_ch.restart = 1'($urandom_range(1));
			@(negedge clk);
		end
		req_ch.valid   = 1'b1;
		req_ch.restart = restart;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		words_due.push_back(next_word(restart));
	endtask

	// hold requests off until every word is out and the block is quiet
	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			REG_KEY01: key_reg[0] = val;
			REG_KEY23: key_reg[1] = val;
			REG_KEY45: key_reg[2] = val;
			REG_KEY67: key_reg[3] = val;
			REG_NONCE: nonce_reg = val;
			REG_START: start_reg = val;
			default: ;
		endcase
	endtask

	task automatic test_reset_defaults();
		send_request(1'b0);
		send_request(1'b0);
	endtask

	// all-ones key and nonce; counter starts at its top value and wraps
	task automatic test_counter_wrap();
		settle();
		write_reg(REG_KEY01, '1);
		write_reg(REG_KEY23, '1);
		write_reg(REG_KEY45, '1);
		write_reg(REG_KEY67, '1);
		write_reg(REG_NONCE, '1);
		write_reg(REG_START, '1);
		send_request(1'b1);
		for (int i = 0; i < WORDS; i++)
			send_request(1'b0);
	endtask

	// new key and start value must not touch the words already buffered
	task automatic test_live_registers();
		settle();
		write_reg(REG_KEY01, '0);
		write_reg(REG_KEY45, 64'h0123_4567_89ab_cdef);
		write_reg(REG_NONCE, '0);
		write_reg(REG_START, '0);
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
	endtask

	function automatic logic [63:0] pick_value(bit near_wrap);
		logic [63:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		if (near_wrap && $urandom_range(3) == 0)
			v = 64'hffff_ffff_ffff_ffff - $urandom_range(3);
		return v;
	endfunction

	task automatic test_random_phases();
		int unsigned sent;
		int unsigned phase;
		int unsigned len;
		logic        first;
		sent  = 0;
		phase = 0;
		while (sent < ITEMS) begin
			settle();
			if ($urandom_range(9) < 6) write_reg(REG_KEY01, pick_value(1'b0));
			if ($urandom_range(9) < 6) write_reg(REG_KEY23, pick_value(1'b0));
			if ($urandom_range(9) < 6) write_reg(REG_KEY45, pick_value(1'b0));
			if ($urandom_range(9) < 6) write_reg(REG_KEY67, pick_value(1'b0));
			if ($urandom_range(9) < 6) write_reg(REG_NONCE, pick_value(1'b0));
			if ($urandom_range(9) < 6) write_reg(REG_START, pick_value(1'b1));
			calm  = (phase == 0) || ($urandom_range(5) == 0);
			len   = $urandom_range(40, 200);
			first = ($urandom_range(9) != 0);
			for (int k = 0; k < len; k++) begin
				send_request(k == 0 ? first : ($urandom_range(99) < 4));
				sent++;
			end
			calm = 1'b0;
			phase++;
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = REG_KEY01;
		cfg_data       = '0;
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;
		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		nonce_reg = '0;
		start_reg = '0;
		blk_ctr   = '0;
		ks_pos    = WORDS;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_counter_wrap();
		test_live_registers();
		test_random_phases();
		settle();

		if (errors == 0)
			$display("chacha20_keystream_generator_top regression: pass");
		else
			$display("chacha20_keystream_generator_top regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
design/cc20_pkg.sv
design/cc20_req_if.sv
design/cc20_word_if.sv
design/cc20_ctrl.sv
design/cc20_core.sv
design/chacha20_keystream_generator_top.sv
design/cc20_chk.sv
tb/testbench.sv
